@@ hw/rtl/pstm_pkg.sv @@
// Package for the patience sort tournament merge block: payload structs and
// default sizes. No dependencies.
`default_nettype none
package pstm_pkg;
	localparam int DefMaxItems = 64;
	localparam int DefKeyBits  = 32;

	typedef struct packed {
		logic [31:0] key;
		logic        last_item;
	} pstm_in_t;

	typedef struct packed {
		logic [5:0]  sorted_index;
		logic [31:0] sorted_key;
		logic        final_result;
	} pstm_out_t;
endpackage
`default_nettype wire

@@ hw/rtl/patience_sort_tournament_merge.sv @@
// Top level of the patience sort tournament merge block: key store, deal
// sequencer, tournament tree and output register. Depends on pstm_pkg, pstm_cmp.
`default_nettype none
// Keys are taken one beat per cycle while the block collects a set; the beat
// marked last_item starts a run and the input stalls until the last sorted beat
// has been produced. A run deals the keys last to first with a binary search
// over the pile heads: each key is set up, then each search step reads a pile
// head, reads its key and compares. It then loads the leaves of a winner tree,
// clearing each empty slot and copying each pile head into its leaf, and builds
// it bottom up, reading each inner node's sibling pair, then their keys, then
// contesting them; ext, the leaf count, is the pile count rounded up to a power
// of two. Each sorted beat reads the root, then its key and the winner's link,
// and refills the leaf from its pile, then replays the path up to the root; a
// beat that is still stalled at the output holds the next root read back.
// All comparisons go through the single shared comparator, one per cycle, and
// every store is read into a register. Results carry the arrival index, the key
// and final_result on the last beat. Keys beyond MAX_ITEMS are dropped.
module patience_sort_tournament_merge
	import pstm_pkg::*;
#(
	parameter int MAX_ITEMS = DefMaxItems,
	parameter int KEY_BITS  = DefKeyBits
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire pstm_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output pstm_out_t      out_data
);
	localparam int AW = $clog2(MAX_ITEMS);      // element index width
	localparam int EW = AW + 1;                  // element number, 0 = none
	localparam int TW = AW + 1;                  // tree slot index width
	localparam int TS = 2 * (1 << AW);

	// Phase of the tree pass: build, first pile of a deal, or replay.
	localparam logic [1:0] PH_BUILD  = 2'd0;
	localparam logic [1:0] PH_OPEN   = 2'd1;
	localparam logic [1:0] PH_REPLAY = 2'd2;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_DEAL  = 13'b0000000000010,  // start element: set up search
		S_SRD   = 13'b0000000000100,  // read pile head at mid
		S_SKEY  = 13'b0000000001000,  // read key of that head
		S_SCMP  = 13'b0000000010000,  // compare, narrow the range
		S_LEAF  = 13'b0000000100000,  // clear a slot or read a pile head
		S_LFW   = 13'b0000001000000,  // write that head into its leaf
		S_BRD   = 13'b0000010000000,  // read sibling pair
		S_BKEY  = 13'b0000100000000,
		S_BCMP  = 13'b0001000000000,  // contest and promote
		S_EMIT  = 13'b0010000000000,
		S_WAIT  = 13'b0100000000000,
		S_ADV   = 13'b1000000000000   // send beat, refill leaf from its pile
	} st_t;
	st_t st_q;

	logic key_signed_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_signed_q <= 1'b0;
		else if (cfg_we) key_signed_q <= cfg_wdata;
	end

	// Memories: keys, pile heads, links, tree winners and sources.
	logic [KEY_BITS-1:0] key_mem [MAX_ITEMS];
	logic [EW-1:0] head_mem [MAX_ITEMS];
	logic [EW-1:0] link_mem [MAX_ITEMS];
	logic [EW-1:0] win_mem [TS];
	logic [EW-1:0] src_mem [TS];

	logic [EW:0] cnt_q, q_q, pc_q, s_idx_q;
	logic [AW:0] lo_q, hi_q;
	logic [TW:0] ext_q, lvl_q, node_q;
	logic [KEY_BITS-1:0] qkey_q, ka_q, kb_q, cmp_a, cmp_b;
	logic [EW-1:0] wa_q, wb_q, sa_q, sb_q;
	logic [1:0]    ph_q;
	logic          less;
	pstm_out_t     obuf_q;

	logic          take, open_pile, join_pile, leaf_hit, leaf_clear;
	logic          right_wins, last_beat;
	logic [AW:0]   mid;
	logic [AW-1:0] q_idx, wa_idx, wb_idx, leaf_pile;
	logic [TW-1:0] node_slot, lvl_slot, left_slot, right_slot, leaf_slot;

	// The replayed child keeps ties, so a replayed right child asks left < right.
	always_comb begin
		priority if (st_q == S_SCMP) begin
			cmp_a = ka_q;
			cmp_b = qkey_q;
		end else if (ph_q == PH_REPLAY && node_q[0]) begin
			cmp_a = ka_q;
			cmp_b = kb_q;
		end else begin
			cmp_a = kb_q;
			cmp_b = ka_q;
		end
	end

	pstm_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
		.a(cmp_a), .b(cmp_b), .key_signed(key_signed_q), .less(less));

	assign in_stall = (st_q != S_IDLE);
	assign out_data = obuf_q;

	assign take = (st_q == S_IDLE) && in_valid && (cnt_q < (EW+1)'(MAX_ITEMS));
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign q_idx = AW'(q_q - 1'b1);
	assign wa_idx = AW'(wa_q - 1'b1);
	assign wb_idx = AW'(wb_q - 1'b1);
	assign open_pile = (st_q == S_SCMP) && (ph_q == PH_OPEN ||
		(lo_q == hi_q && less && (lo_q + 1'b1 == pc_q[AW:0])));
	assign join_pile = (st_q == S_SCMP) && (ph_q != PH_OPEN) && (lo_q == hi_q) && !open_pile;
	assign leaf_hit = (node_q >= ext_q) && ((node_q - ext_q) < pc_q);
	assign leaf_clear = (st_q == S_LEAF) && !(ext_q < pc_q) &&
		(node_q < (ext_q << 1)) && !leaf_hit;
	assign leaf_pile = AW'(node_q - ext_q);
	assign node_slot = node_q[TW-1:0];
	assign lvl_slot = lvl_q[TW-1:0];
	assign left_slot = {lvl_q[TW-2:0], 1'b0};
	assign right_slot = {lvl_q[TW-2:0], 1'b1};
	assign leaf_slot = TW'(ext_q + (TW+1)'(sa_q) - 1'b1);
	assign last_beat = (s_idx_q + 1'b1 == cnt_q);
	// An empty slot always loses.
	assign right_wins = (wa_q == '0) ||
		((wb_q != '0) && ((ph_q == PH_REPLAY && node_q[0]) ? !less : less));

	always_ff @(posedge clk) begin
		if (take) key_mem[cnt_q[AW-1:0]] <= KEY_BITS'(in_data.key);
	end

	// Pile and tree stores are written here, at most one entry of each store per cycle.
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_DEAL: if (q_q != '0) link_mem[q_idx] <= '0;
			S_SCMP: begin
				if (open_pile) head_mem[pc_q[AW-1:0]] <= q_q[EW-1:0];
				if (join_pile) begin
					link_mem[q_idx] <= wa_q;
					head_mem[lo_q[AW-1:0]] <= q_q[EW-1:0];
				end
			end
			S_LEAF: if (leaf_clear) begin
				win_mem[node_slot] <= '0;
				src_mem[node_slot] <= '0;
			end
			S_LFW: begin
				win_mem[node_slot] <= wa_q;
				src_mem[node_slot] <= EW'(node_q - ext_q + 1'b1);
			end
			S_BCMP: begin
				win_mem[lvl_slot] <= right_wins ? wb_q : wa_q;
				src_mem[lvl_slot] <= right_wins ? sb_q : sa_q;
			end
			S_ADV: if (!last_beat) win_mem[leaf_slot] <= wb_q;
			default: ;
		endcase
	end

	// Sequencer: one shared compare per cycle, every store read into a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; cnt_q <= '0; pc_q <= '0; out_valid <= 1'b0;
			q_q <= '0; s_idx_q <= '0; ph_q <= PH_BUILD;
			lo_q <= '0; hi_q <= '0; ext_q <= '0; lvl_q <= '0; node_q <= '0;
			qkey_q <= '0; ka_q <= '0; kb_q <= '0;
			wa_q <= '0; wb_q <= '0; sa_q <= '0; sb_q <= '0;
			obuf_q <= '0;
		end else begin
			if (st_q == S_ADV) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					if (cnt_q < (EW+1)'(MAX_ITEMS)) cnt_q <= cnt_q + 1'b1;
					if (in_data.last_item) begin
						q_q <= (cnt_q < (EW+1)'(MAX_ITEMS)) ? cnt_q + 1'b1 : cnt_q;
						pc_q <= '0; st_q <= S_DEAL;
					end
				end
				S_DEAL: begin
					if (q_q == '0) begin
						ext_q <= (TW+1)'(1); st_q <= S_LEAF; node_q <= '0;
					end else begin
						qkey_q <= key_mem[q_idx];
						lo_q <= '0;
						hi_q <= (pc_q == '0) ? '0 : (AW+1)'(pc_q - 1'b1);
						st_q <= (pc_q == '0) ? S_SCMP : S_SRD;
						ph_q <= (pc_q == '0) ? PH_OPEN : PH_BUILD;
					end
				end
				S_SRD: begin wa_q <= head_mem[mid[AW-1:0]]; st_q <= S_SKEY; end
				S_SKEY: begin ka_q <= key_mem[wa_idx]; st_q <= S_SCMP; end
				S_SCMP: begin
					if (open_pile) begin
						pc_q <= pc_q + 1'b1;
						q_q <= q_q - 1'b1; st_q <= S_DEAL;
					end else if (lo_q != hi_q) begin
						if (less) lo_q <= mid + 1'b1; else hi_q <= mid;
						st_q <= S_SRD;
					end else begin
						q_q <= q_q - 1'b1; st_q <= S_DEAL;
					end
				end
				S_LEAF: begin
					// Grow ext first, then clear empty slots and load each pile head.
					if (ext_q < pc_q) ext_q <= ext_q << 1;
					else if (node_q < (ext_q << 1)) begin
						if (leaf_hit) begin
							wa_q <= head_mem[leaf_pile]; st_q <= S_LFW;
						end else node_q <= node_q + 1'b1;
					end else begin
						lvl_q <= ext_q - 1'b1; st_q <= S_BRD; ph_q <= PH_BUILD;
					end
				end
				S_LFW: begin node_q <= node_q + 1'b1; st_q <= S_LEAF; end
				S_BRD: begin
					if (lvl_q == '0) begin
						s_idx_q <= '0; st_q <= S_EMIT;
					end else begin
						wa_q <= win_mem[left_slot];
						wb_q <= win_mem[right_slot];
						sa_q <= src_mem[left_slot];
						sb_q <= src_mem[right_slot];
						st_q <= S_BKEY;
					end
				end
				S_BKEY: begin
					ka_q <= key_mem[wa_idx];
					kb_q <= key_mem[wb_idx];
					st_q <= S_BCMP;
				end
				S_BCMP: begin
					if (ph_q == PH_REPLAY) begin
						node_q <= lvl_q;
						lvl_q <= lvl_q >> 1;
						if (lvl_q == (TW+1)'(1)) st_q <= S_EMIT; else st_q <= S_BRD;
					end else begin
						lvl_q <= lvl_q - 1'b1;
						st_q <= S_BRD;
					end
				end
				S_EMIT: if (!out_valid || !out_stall) begin
					wa_q <= win_mem[TW'(1)]; sa_q <= src_mem[TW'(1)]; st_q <= S_WAIT;
				end
				S_WAIT: begin
					// The next element of the winner's pile is the winner's link.
					ka_q <= key_mem[wa_idx];
					wb_q <= (wa_q == '0) ? '0 : link_mem[wa_idx];
					st_q <= S_ADV;
				end
				S_ADV: begin
					obuf_q.sorted_index <= (wa_q == '0) ? '0 : 6'(wa_idx);
					obuf_q.sorted_key <= (wa_q == '0) ? '0 : 32'(ka_q);
					obuf_q.final_result <= last_beat;
					s_idx_q <= s_idx_q + 1'b1;
					if (last_beat) begin
						cnt_q <= '0; st_q <= S_IDLE;
					end else begin
						node_q <= (TW+1)'(leaf_slot);
						lvl_q <= (TW+1)'(leaf_slot >> 1);
						ph_q <= PH_REPLAY;
						st_q <= (ext_q == (TW+1)'(1)) ? S_EMIT : S_BRD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	ap_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data)) else $error("stalled beat changed");
	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall || out_data.final_result) else $error("input open mid run");
	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (EW+1)'(MAX_ITEMS)) else $error("count overflow");
endmodule
`default_nettype wire

@@ hw/rtl/pstm_cmp.sv @@
// Shared key comparator of the sort block: a < b, signed or unsigned.
// Depends on pstm_pkg.
`default_nettype none
module pstm_cmp
	import pstm_pkg::*;
#(
	parameter int KEY_BITS = DefKeyBits
) (
	input  wire logic [KEY_BITS-1:0] a,
	input  wire logic [KEY_BITS-1:0] b,
	input  wire logic                key_signed,
	output logic                     less
);
	logic [KEY_BITS-1:0] sb;
	always_comb begin
		sb = '0;
		sb[KEY_BITS-1] = key_signed;
		less = (a ^ sb) < (b ^ sb);
	end
endmodule
`default_nettype wire
